[rtl/core/rgb_rect_variance_from_integral_image_assert.svh]
// Assertion helpers shared by the RTL.
`ifndef RGB_RECT_VARIANCE_FROM_INTEGRAL_IMAGE_ASSERT_SVH
`define RGB_RECT_VARIANCE_FROM_INTEGRAL_IMAGE_ASSERT_SVH

`ifndef SYNTHESIS
`define RRV_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rrv assertion failed");
`define RRV_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rrv forbidden condition");
`else
`define RRV_ASSERT(label, clk, rst, prop)
`define RRV_NEVER(label, clk, rst, cond)
`endif

`endif

[rtl/core/rrv_pkg.sv]
package rrv_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

  localparam int DIM_W  = 9;
  localparam int SUM_W  = 24;
  localparam int SQ_W   = 32;
  localparam int WORD_W = 3 * (SUM_W + SQ_W);
  localparam int SQ_OFS = 3 * SUM_W;
  localparam int AREA_W = 17;
  localparam int DEV_W  = 34;
  localparam int DIVD_W = 2 * SUM_W;
  localparam int CNT_W  = $clog2(DIVD_W);

  localparam int IN_W  = 56;
  localparam int OUT_W = 80;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;

  localparam logic [2:0] REG_ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] REG_ADDR_HEIGHT = 3'd4;

endpackage

[rtl/core/rgb_rect_variance_from_integral_image.sv]
// RGB rectangle statistics over summed-area tables. A load transfer (tuser 0)
// writes one pixel in raster order and holds off the input until the pixel is
// written. A valid query transfer (tuser 1) holds it off through four table
// reads, then, for each channel, two 48-step restoring divisions (mean and
// square-of-sum over area) on one shared divider, and the registering of the
// result. An inverted or out-of-image query skips the reads and divisions and
// gives status 1 with zeroed fields. A load outside the image is dropped.
// Loads give no result and each query gives one. A result still held at the
// output delays the next query's result, and with it the input. The six tables
// share one 65536-entry memory with no reset, so only rectangles whose corners
// were loaded give defined results.
module rgb_rect_variance_from_integral_image (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // left_col, top_row, right_col, bottom_row, red_value, green_value, blue_value
  input  logic [rrv_pkg::IN_W-1:0]      s_tdata,
  // req_type
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status, pixel_count, deviation_score, avg_red, avg_green, avg_blue, pad
  output logic [rrv_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rrv_pkg::*;
  `include "rgb_rect_variance_from_integral_image_assert.svh"

  typedef enum logic [2:0] {
    IDLE, READ, ACC, WRITE, DIV_LOAD, DIV, POST, OUT
  } state_t;

  state_t state;

  logic [DIM_W-1:0] image_width, image_height;
  logic [DIM_W-1:0] eff_w, eff_h;

  logic             kind;
  logic [7:0]       lc, tr, rc, br;
  logic [1:0]       k;
  logic [1:0]       ch;
  logic             phase;
  logic             bad;
  logic [AREA_W-1:0] area;
  logic [SUM_W-1:0] acc_sum [3];
  logic [SQ_W-1:0]  acc_sq  [3];
  logic [7:0]       avg     [3];
  logic [DEV_W-1:0] dev;
  logic [DIVD_W-1:0] dq;
  logic [AREA_W-1:0] rem;
  logic [CNT_W-1:0] dcnt;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic              mem_we;
  logic [WORD_W-1:0] wdata;

  // Input fields
  logic [7:0] in_l, in_t, in_r, in_b;
  logic [7:0] in_v [3];
  assign in_l    = s_tdata[7:0];
  assign in_t    = s_tdata[15:8];
  assign in_r    = s_tdata[23:16];
  assign in_b    = s_tdata[31:24];
  assign in_v[0] = s_tdata[39:32];
  assign in_v[1] = s_tdata[47:40];
  assign in_v[2] = s_tdata[55:48];

  assign eff_w = (image_width  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : image_width;
  assign eff_h = (image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : image_height;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {23'd0, image_height} : {23'd0, image_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(256);
      image_height <= DIM_W'(256);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) image_height <= pwdata[DIM_W-1:0];
      else image_width <= pwdata[DIM_W-1:0];
    end
  end

  // Corner selection for the current read
  logic [7:0] sel_col, sel_row;
  logic       sel_zero, sel_neg;
  always_comb begin
    sel_col  = rc;
    sel_row  = br;
    sel_zero = 1'b0;
    sel_neg  = 1'b0;
    if (kind == REQ_LOAD) begin
      unique case (k)
        2'd0: begin sel_col = lc - 8'd1; sel_row = tr; sel_zero = (lc == 8'd0); end
        2'd1: begin sel_col = lc; sel_row = tr - 8'd1; sel_zero = (tr == 8'd0); end
        default: begin
          sel_col  = lc - 8'd1;
          sel_row  = tr - 8'd1;
          sel_zero = (lc == 8'd0) || (tr == 8'd0);
          sel_neg  = 1'b1;
        end
      endcase
    end else begin
      unique case (k)
        2'd0: begin sel_col = rc; sel_row = br; end
        2'd1: begin
          sel_col = rc; sel_row = tr - 8'd1; sel_zero = (tr == 8'd0); sel_neg = 1'b1;
        end
        2'd2: begin
          sel_col = lc - 8'd1; sel_row = br; sel_zero = (lc == 8'd0); sel_neg = 1'b1;
        end
        default: begin
          sel_col  = lc - 8'd1;
          sel_row  = tr - 8'd1;
          sel_zero = (lc == 8'd0) || (tr == 8'd0);
        end
      endcase
    end
  end

  assign raddr  = {sel_row[ROW_W-1:0], sel_col[COL_W-1:0]};
  assign mem_we = (state == WRITE);
  always_comb begin
    wdata = '0;
    for (int c = 0; c < 3; c++) begin
      wdata[c*SUM_W +: SUM_W]         = acc_sum[c];
      wdata[SQ_OFS + c*SQ_W +: SQ_W]  = acc_sq[c];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[{tr[ROW_W-1:0], lc[COL_W-1:0]}] <= wdata;
    rdata <= mem[raddr];
  end

  // Shared divider step: dq shifts the dividend out and the quotient in
  logic [AREA_W:0]   div_t;
  logic              div_ge;
  logic [AREA_W:0]   div_diff;
  assign div_t    = {rem, dq[DIVD_W-1]};
  assign div_ge   = div_t >= {1'b0, area};
  assign div_diff = div_t - {1'b0, area};

  logic [DIM_W-1:0]     span_w, span_h;
  logic [2*DIM_W-1:0]   area_full;
  assign span_w    = DIM_W'(in_r) - DIM_W'(in_l) + DIM_W'(1);
  assign span_h    = DIM_W'(in_b) - DIM_W'(in_t) + DIM_W'(1);
  assign area_full = span_w * span_h;

  logic in_xfer;
  assign in_xfer  = s_tvalid && s_tready;
  assign s_tready = (state == IDLE);

  logic [SUM_W-1:0] term_s [3];
  logic [SQ_W-1:0]  term_q [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      term_s[c] = sel_zero ? '0 : rdata[c*SUM_W +: SUM_W];
      term_q[c] = sel_zero ? '0 : rdata[SQ_OFS + c*SQ_W +: SQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != OUT) m_tvalid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (in_xfer) begin
            kind <= s_tuser;
            lc <= in_l; tr <= in_t; rc <= in_r; br <= in_b;
            k <= 2'd0; ch <= 2'd0; phase <= 1'b0;
            dev <= '0;
            area <= area_full[AREA_W-1:0];
            for (int c = 0; c < 3; c++) begin
              acc_sum[c] <= (s_tuser == REQ_LOAD) ? SUM_W'(in_v[c]) : '0;
              acc_sq[c]  <= (s_tuser == REQ_LOAD) ? SQ_W'(in_v[c] * in_v[c]) : '0;
            end
            if (s_tuser == REQ_LOAD) begin
              bad <= 1'b0;
              if ((DIM_W'(in_l) < eff_w) && (DIM_W'(in_t) < eff_h)) state <= READ;
            end else if ((in_l > in_r) || (in_t > in_b) ||
                         (DIM_W'(in_r) >= eff_w) || (DIM_W'(in_b) >= eff_h)) begin
              bad   <= 1'b1;
              state <= OUT;
            end else begin
              bad   <= 1'b0;
              state <= READ;
            end
          end
        end
        READ: state <= ACC;
        ACC: begin
          for (int c = 0; c < 3; c++) begin
            acc_sum[c] <= sel_neg ? acc_sum[c] - term_s[c] : acc_sum[c] + term_s[c];
            acc_sq[c]  <= sel_neg ? acc_sq[c]  - term_q[c] : acc_sq[c]  + term_q[c];
          end
          k <= k + 2'd1;
          if (kind == REQ_LOAD && k == 2'd2) state <= WRITE;
          else if (kind == REQ_QUERY && k == 2'd3) state <= DIV_LOAD;
          else state <= READ;
        end
        WRITE: state <= IDLE;
        DIV_LOAD: begin
          dq   <= phase ? DIVD_W'(acc_sum[ch] * acc_sum[ch]) : DIVD_W'(acc_sum[ch]);
          rem  <= '0;
          dcnt <= '0;
          state <= DIV;
        end
        DIV: begin
          dq   <= {dq[DIVD_W-2:0], div_ge};
          rem  <= div_ge ? div_diff[AREA_W-1:0] : div_t[AREA_W-1:0];
          dcnt <= dcnt + CNT_W'(1);
          if (dcnt == CNT_W'(DIVD_W-1)) state <= POST;
        end
        POST: begin
          if (!phase) begin
            avg[ch] <= (|dq[DIVD_W-1:8]) ? 8'hFF : dq[7:0];
            phase   <= 1'b1;
            state   <= DIV_LOAD;
          end else begin
            dev   <= dev + DEV_W'(acc_sq[ch]) - dq[DEV_W-1:0];
            phase <= 1'b0;
            if (ch == 2'd2) state <= OUT;
            else begin
              ch    <= ch + 2'd1;
              state <= DIV_LOAD;
            end
          end
        end
        OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (bad) m_tdata <= {{(OUT_W-1){1'b0}}, ST_BAD};
            else m_tdata <= {4'd0, avg[2], avg[1], avg[0], dev, area, ST_OK};
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `RRV_ASSERT(a_valid_area, clk, rst, (m_tvalid && m_tdata[0] == ST_OK) |-> (m_tdata[17:1] != '0))
  `RRV_ASSERT(a_bad_zero, clk, rst, (m_tvalid && m_tdata[0] == ST_BAD) |-> (m_tdata[OUT_W-1:1] == '0))
  `RRV_ASSERT(a_load_quiet, clk, rst, (in_xfer && s_tuser == REQ_LOAD) |=> !$rose(m_tvalid))
  `RRV_NEVER(a_div_count, clk, rst, (state == DIV) && (dcnt > CNT_W'(DIVD_W-1)))

endmodule

[verif/rgb_rect_variance_from_integral_image_tb.sv]
`timescale 1ns / 1ps

module rgb_rect_variance_from_integral_image_tb;
  import rrv_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int CELLS          = MAX_WIDTH * MAX_HEIGHT;
  localparam int ITEM_TARGET    = 1050;

  typedef struct packed {
    logic        status;
    logic [16:0] pixel_count;
    logic [33:0] deviation_score;
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
  } rect_stats_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  rgb_rect_variance_from_integral_image DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  bit [31:0]   sum_tab[3][CELLS];
  bit [31:0]   sq_tab[3][CELLS];
  bit          loaded[CELLS];
  bit [8:0]    width_reg;
  bit [8:0]    height_reg;

  rect_stats_t stats_q[$];
  int          errors;
  int          items_sent;
  bit          quiet;
  int          idle_cnt;
  int          stall_left;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int img_w();
    return (width_reg < MAX_WIDTH) ? width_reg : MAX_WIDTH;
  endfunction

  function automatic int img_h();
    return (height_reg < MAX_HEIGHT) ? height_reg : MAX_HEIGHT;
  endfunction

  function automatic int cell_at(int col, int row);
    return row * MAX_WIDTH + col;
  endfunction

  function automatic bit [31:0] entry(int k, bit sq, int col, int row);
    if (col < 0 || row < 0) return 32'd0;
    return sq ? sq_tab[k][cell_at(col, row)] : sum_tab[k][cell_at(col, row)];
  endfunction

  function automatic void store_pixel(int col, int row, bit [7:0] pix[3]);
    bit [31:0] v;
    for (int k = 0; k < 3; k++) begin
      v = pix[k] + entry(k, 0, col - 1, row) + entry(k, 0, col, row - 1)
          - entry(k, 0, col - 1, row - 1);
      sum_tab[k][cell_at(col, row)] = v & 32'hFF_FFFF;
      v = pix[k] * pix[k] + entry(k, 1, col - 1, row) + entry(k, 1, col, row - 1)
          - entry(k, 1, col - 1, row - 1);
      sq_tab[k][cell_at(col, row)] = v;
    end
    loaded[cell_at(col, row)] = 1'b1;
  endfunction

  function automatic bit [31:0] box_total(int k, bit sq, int l, int t, int r, int b);
    bit [31:0] v;
    v = entry(k, sq, r, b) - entry(k, sq, r, t - 1) - entry(k, sq, l - 1, b)
        + entry(k, sq, l - 1, t - 1);
    return sq ? v : (v & 32'hFF_FFFF);
  endfunction

  function automatic rect_stats_t rect_stats(int l, int t, int r, int b);
    rect_stats_t res;
    logic [63:0] area;
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] dev;
    logic [63:0] mean;
    logic [7:0]  avg[3];
    res = '0;
    if (l > r || t > b || r >= img_w() || b >= img_h()) begin
      res.status = ST_BAD;
      return res;
    end
    area = (r - l + 1) * (b - t + 1);
    dev = 0;
    for (int k = 0; k < 3; k++) begin
      s = box_total(k, 0, l, t, r, b);
      q = box_total(k, 1, l, t, r, b);
      mean = s / area;
      dev = dev + q - (s * s) / area;
      avg[k] = (mean > 255) ? 8'd255 : mean[7:0];
    end
    res.status = ST_OK;
    res.pixel_count = area[16:0];
    res.deviation_score = dev[33:0];
    res.avg_red = avg[0];
    res.avg_green = avg[1];
    res.avg_blue = avg[2];
    return res;
  endfunction

  // a query may only touch entries that were loaded since reset
  function automatic bit corners_loaded(int l, int t, int r, int b);
    if (l > r || t > b || r >= img_w() || b >= img_h()) return 1'b1;
    if (!loaded[cell_at(r, b)]) return 1'b0;
    if (t > 0 && !loaded[cell_at(r, t - 1)]) return 1'b0;
    if (l > 0 && !loaded[cell_at(l - 1, b)]) return 1'b0;
    if (l > 0 && t > 0 && !loaded[cell_at(l - 1, t - 1)]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(logic kind, int l, int t, int r, int b,
                           logic [7:0] rv, logic [7:0] gv, logic [7:0] bv);
    int gap;
    bit [7:0] pix[3];
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {bv, gv, rv, b[7:0], r[7:0], t[7:0], l[7:0]};
    do @(posedge clk); while (!s_tready);
    pix[0] = rv;
    pix[1] = gv;
    pix[2] = bv;
    if (kind == REQ_LOAD) begin
      if (l < img_w() && t < img_h()) store_pixel(l, t, pix);
    end else begin
      stats_q.push_back(rect_stats(l, t, r, b));
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_pixel(int col, int row);
    send_item(REQ_LOAD, col, row, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic query_rect(int l, int t, int r, int b);
    send_item(REQ_QUERY, l, t, r, b, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255));
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, exp);
    errors++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (stats_q.size() != 0) @(negedge clk);
    // a load still in flight gives no result
    repeat (20) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[8:0] !== data[8:0]) report_mismatch("register readback", prdata, data[8:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_image_size(int w, int h);
    drain();
    apb_write(REG_ADDR_WIDTH, w);
    width_reg = w[8:0];
    apb_write(REG_ADDR_HEIGHT, h);
    height_reg = h[8:0];
  endtask

  task automatic test_directed();
    set_image_size(4, 3);
    send_item(REQ_LOAD, 0, 0, 255, 255, 8'd255, 8'd0, 8'd255);
    for (int i = 1; i < 12; i++)
      send_item(REQ_LOAD, i % 4, i / 4, 0, 0, (i % 2) ? 8'd0 : 8'd255, 8'd255,
                i * 20);
    send_item(REQ_LOAD, 5, 0, 0, 0, 8'd1, 8'd2, 8'd3);       // column outside image
    send_item(REQ_LOAD, 0, 200, 0, 0, 8'd1, 8'd2, 8'd3);     // row outside image
    send_item(REQ_QUERY, 0, 0, 3, 2, 8'd255, 8'd255, 8'd255);
    query_rect(0, 0, 0, 0);
    query_rect(3, 2, 3, 2);
    query_rect(1, 1, 2, 2);
    query_rect(2, 0, 1, 2);                                  // inverted columns
    query_rect(0, 2, 3, 1);                                  // inverted rows
    query_rect(0, 0, 4, 0);                                  // right beyond width
    query_rect(0, 0, 0, 3);                                  // bottom beyond height
    query_rect(255, 255, 255, 255);
    // out-of-order reload leaves the tables inconsistent
    send_item(REQ_LOAD, 1, 1, 0, 0, 8'd0, 8'd0, 8'd0);
    query_rect(1, 1, 1, 1);
    query_rect(2, 2, 3, 2);
    query_rect(0, 0, 3, 2);
  endtask

  task automatic test_wide_image();
    set_image_size(511, 1);                                  // clamps to the maximum
    for (int c = 0; c < 256; c++) load_pixel(c, 0);
    query_rect(0, 0, 255, 0);
    query_rect(255, 0, 255, 0);
    for (int i = 0; i < 6; i++) begin
      int a;
      int z;
      a = $urandom_range(0, 255);
      z = $urandom_range(a, 255);
      query_rect(a, 0, z, 0);
    end
    query_rect(0, 0, 0, 1);
  endtask

  task automatic test_tall_image();
    set_image_size(1, 256);
    for (int r = 0; r < 256; r++) load_pixel(0, r);
    query_rect(0, 0, 0, 255);
    query_rect(0, 128, 0, 255);
    query_rect(1, 0, 1, 0);
  endtask

  task automatic test_zero_size();
    set_image_size(0, 5);
    load_pixel(0, 0);
    query_rect(0, 0, 0, 0);
    set_image_size(5, 0);
    load_pixel(0, 0);
    query_rect(0, 0, 0, 0);
  endtask

  task automatic test_random();
    int w;
    int h;
    int n;
    int l;
    int t;
    int r;
    int b;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > 900) quiet = 1'b1;
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 9);
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 9);
      set_image_size(w, h);
      for (int y = 0; y < h && items_sent < ITEM_TARGET; y++)
        for (int x = 0; x < w && items_sent < ITEM_TARGET; x++) begin
          load_pixel(x, y);
          if ($urandom_range(0, 9) == 0)
            load_pixel($urandom_range(w, 255), $urandom_range(0, 255));
          if ($urandom_range(0, 19) == 0) load_pixel($urandom_range(0, x), y);
        end
      n = $urandom_range(6, 16);
      for (int i = 0; i < n && items_sent < ITEM_TARGET; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          l = $urandom_range(0, 255);
          t = $urandom_range(0, 255);
          r = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end else begin
          l = $urandom_range(0, w - 1);
          r = $urandom_range(l, w - 1);
          t = $urandom_range(0, h - 1);
          b = $urandom_range(t, h - 1);
        end
        if (corners_loaded(l, t, r, b)) query_rect(l, t, r, b);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    rect_stats_t got;
    rect_stats_t exp;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[75:0];
      got.status = m_tdata[0];
      got.pixel_count = m_tdata[17:1];
      got.deviation_score = m_tdata[51:18];
      got.avg_red = m_tdata[59:52];
      got.avg_green = m_tdata[67:60];
      got.avg_blue = m_tdata[75:68];
      if (stats_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
      end else begin
        exp = stats_q.pop_front();
        if (got.status !== exp.status) report_mismatch("status", got.status, exp.status);
        if (got.pixel_count !== exp.pixel_count)
          report_mismatch("pixel_count", got.pixel_count, exp.pixel_count);
        if (got.deviation_score !== exp.deviation_score)
          report_mismatch("deviation_score", got.deviation_score, exp.deviation_score);
        if (got.avg_red !== exp.avg_red) report_mismatch("avg_red", got.avg_red, exp.avg_red);
        if (got.avg_green !== exp.avg_green)
          report_mismatch("avg_green", got.avg_green, exp.avg_green);
        if (got.avg_blue !== exp.avg_blue)
          report_mismatch("avg_blue", got.avg_blue, exp.avg_blue);
      end
    end
  end

  // receiver backpressure in bursts
  always @(negedge clk) begin
    if (rst || quiet) begin
      m_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("rgb_rect_variance_from_integral_image: mismatch");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_LOAD;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    items_sent = 0;
    quiet = 1'b0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    repeat (7) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_zero_size();
    test_wide_image();
    test_tall_image();
    test_random();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (stats_q.size() != 0)
      report_mismatch("results never arrived", 64'(stats_q.size()), 64'd0);
    if (errors == 0) begin
      $display("rgb_rect_variance_from_integral_image: match");
    end else begin
      $display("rgb_rect_variance_from_integral_image: mismatch");
    end
    $finish;
  end

endmodule
